// File: src/congestion_window_update_macros.svh
// Assertion macros shared by the congestion window update design.
`ifndef CONGESTION_WINDOW_UPDATE_MACROS_SVH
`define CONGESTION_WINDOW_UPDATE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define CWU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define CWU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/cwu_pkg.sv
// Shared types and constants of the congestion window update block.
package cwu_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned SegW    = 16;
	localparam int unsigned AckedW  = 16;
	localparam int unsigned DivSteps = WordW;
	localparam int unsigned CntW    = $clog2(DivSteps);

	// Values held after reset.
	localparam logic [SegW-1:0]  SEG_SIZE_RST  = 16'd536;
	localparam logic [WordW-1:0] NUMERATOR_RST = 32'd153280;
	localparam logic [WordW-1:0] INIT_WIN_RST  = 32'd536;
	localparam logic [WordW-1:0] INIT_THR_RST  = 32'hFFFF_FFFF;

	// Event kinds carried in the input tuser.
	typedef enum logic [1:0] {
		OP_ACK     = 2'd0,
		OP_LOSS    = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SEGMENT_SIZE      = 2'd0,
		REG_SLOW_START_NUMER  = 2'd1,
		REG_INITIAL_WINDOW    = 2'd2,
		REG_INITIAL_THRESHOLD = 2'd3
	} reg_idx_t;

endpackage

// File: src/congestion_window_update.sv
// Congestion window update block: window and threshold state with a bit-serial divider.
//
// Usage: one event arrives per input beat. s_axis_tuser carries the event kind
// (acknowledgement, loss, restart) and s_axis_tdata carries the acked segment
// count and the bytes in flight. Every event yields exactly one output beat with
// the window, the threshold and the slow-start flag after that event.
// Configuration registers are written through the cfg channel, which is always
// ready; write them only while no event is in progress.
// Steps: a loss or a restart goes from the decide step straight to emit, an
// acknowledgement outside slow start passes through the avoidance step, and a
// slow-start acknowledgement with a zero window through the growth and avoidance
// steps. A slow-start acknowledgement with a nonzero window first runs the radix-2
// restoring divider, one quotient bit per cycle for the 32-bit quotient, then the
// round-up, growth and avoidance steps. The input is ready again the cycle after
// the beat is loaded. One event is worked on at a time.
// The output register holds a finished beat until it is taken; meanwhile the
// next event may be accepted and processed, and it waits in its last step for
// the output register to free up when the receiver stalls.
// Reset loads the register defaults, a window of 536 and an all-ones threshold.
module congestion_window_update
	import cwu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input event stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [15:0] segments_acked, [47:16] bytes_in_flight
	input  logic [1:0]  s_axis_tuser,   // [1:0] operation
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] window_bytes, [63:32] threshold_bytes
	output logic        m_axis_tuser,   // [0] in_slow_start
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_DIV,
		S_FIXUP,
		S_GROW,
		S_AVOID,
		S_EMIT
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [AckedW-1:0] left_q;
	logic [WordW-1:0]  flight_q;
	logic [WordW-1:0]  window_q;
	logic [WordW-1:0]  threshold_q;
	logic [WordW-1:0]  inc_q;
	logic [WordW-1:0]  num_q;
	logic [WordW-1:0]  rem_q;
	logic [CntW-1:0]   cnt_q;

	logic [SegW-1:0]   seg_size_q;
	logic [WordW-1:0]  numer_q;
	logic [WordW-1:0]  init_win_q;
	logic [WordW-1:0]  init_thr_q;

	logic              out_valid_q;
	logic [WordW-1:0]  out_win_q;
	logic [WordW-1:0]  out_thr_q;
	logic              out_ss_q;

	logic              slow_start;
	logic [WordW:0]    div_cand;
	logic [WordW:0]    div_diff;
	logic [WordW-1:0]  loss_floor;
	logic [WordW-1:0]  loss_half;
	logic [WordW:0]    grow_sum;
	logic [WordW:0]    avoid_sum;
	logic              out_free;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_thr_q, out_win_q};
	assign m_axis_tuser  = out_ss_q;

	assign slow_start = (window_q < threshold_q);
	assign out_free   = !out_valid_q || m_axis_tready;

	// One restoring division step: bring down the next dividend bit and try the divisor.
	assign div_cand = {rem_q, num_q[WordW-1]};
	assign div_diff = div_cand - {1'b0, window_q};

	// Loss threshold candidates.
	assign loss_floor = {{(WordW-SegW-1){1'b0}}, seg_size_q, 1'b0};
	assign loss_half  = {1'b0, flight_q[WordW-1:1]};

	// Growth sums, one bit wider to detect saturation.
	assign grow_sum  = {1'b0, window_q} + {1'b0, inc_q};
	assign avoid_sum = {1'b0, window_q} + {{(WordW-SegW+2){1'b0}}, seg_size_q[SegW-1:1]};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_size_q <= SEG_SIZE_RST;
			numer_q    <= NUMERATOR_RST;
			init_win_q <= INIT_WIN_RST;
			init_thr_q <= INIT_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SEGMENT_SIZE:      seg_size_q <= cfg_data[SegW-1:0];
				REG_SLOW_START_NUMER:  numer_q    <= cfg_data;
				REG_INITIAL_WINDOW:    init_win_q <= cfg_data;
				REG_INITIAL_THRESHOLD: init_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Event sequencer, window state, divider and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			window_q    <= INIT_WIN_RST;
			threshold_q <= INIT_THR_RST;
			out_valid_q <= 1'b0;
			op_q        <= OP_ACK;
			left_q      <= '0;
			flight_q    <= '0;
			inc_q       <= '0;
			num_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			out_win_q   <= '0;
			out_thr_q   <= '0;
			out_ss_q    <= 1'b0;
		end else begin
			// The receiver took the waiting beat and no new beat replaces it.
			if (out_valid_q && m_axis_tready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q     <= op_t'(s_axis_tuser);
						left_q   <= s_axis_tdata[AckedW-1:0];
						flight_q <= s_axis_tdata[47:16];
						state_q  <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					unique case (op_q)
						OP_ACK: begin
							if (slow_start && left_q != '0) begin
								left_q <= left_q - 1'b1;
								if (window_q == '0) begin
									inc_q   <= numer_q;
									state_q <= S_GROW;
								end else begin
									num_q   <= numer_q;
									rem_q   <= '0;
									cnt_q   <= '0;
									state_q <= S_DIV;
								end
							end else begin
								state_q <= S_AVOID;
							end
						end
						OP_LOSS: begin
							threshold_q <= (loss_floor > loss_half) ? loss_floor : loss_half;
							state_q     <= S_EMIT;
						end
						OP_RESTART: begin
							window_q    <= init_win_q;
							threshold_q <= init_thr_q;
							state_q     <= S_EMIT;
						end
						default: state_q <= S_EMIT;
					endcase
				end
				S_DIV: begin
					// Quotient bits shift in where dividend bits shift out.
					if (!div_diff[WordW]) begin
						rem_q <= div_diff[WordW-1:0];
						num_q <= {num_q[WordW-2:0], 1'b1};
					end else begin
						rem_q <= div_cand[WordW-1:0];
						num_q <= {num_q[WordW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(DivSteps - 1)) begin
						state_q <= S_FIXUP;
					end
				end
				S_FIXUP: begin
					// Round the quotient up when a remainder is left.
					inc_q   <= num_q + {{(WordW-1){1'b0}}, (rem_q != '0)};
					state_q <= S_GROW;
				end
				S_GROW: begin
					window_q <= grow_sum[WordW] ? '1 : grow_sum[WordW-1:0];
					state_q  <= S_AVOID;
				end
				S_AVOID: begin
					if (op_q == OP_ACK && !slow_start && left_q != '0) begin
						window_q <= avoid_sum[WordW] ? '1 : avoid_sum[WordW-1:0];
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_win_q   <= window_q;
						out_thr_q   <= threshold_q;
						out_ss_q    <= slow_start;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`include "congestion_window_update_macros.svh"

	// The partial remainder always stays below the divisor.
	`CWU_ASSERT_NOW(a_rem_below_div, state_q == S_DIV, rem_q < window_q, "remainder reached divisor")

	// A finished event always lands in the output register and frees the input.
	`CWU_ASSERT_NEXT(a_emit_loads, state_q == S_EMIT && out_free, out_valid_q && state_q == S_IDLE, "emit did not load output")

	// Growth steps never shrink the window.
	`CWU_ASSERT_NEXT(a_window_grows, state_q == S_GROW || state_q == S_AVOID, window_q >= $past(window_q), "window shrank on growth")

	// The threshold changes only when an event is decided.
	`CWU_ASSERT_NEXT(a_thr_stable, state_q != S_DECIDE, $stable(threshold_q), "threshold changed outside decide")

endmodule

// File: bench/tb_congestion_window_update.sv
// Self-checking testbench for the congestion window update block.
`timescale 1ns / 100ps

module tb_congestion_window_update;
	import cwu_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned PHASE_EVENTS = 250;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned MAX_REPORTS = 10;
	// Selector value that the block does not define; it must leave the state alone.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] acked;
		logic [31:0] flight;
	} cwu_event_t;

	typedef struct packed {
		logic [31:0] window;
		logic [31:0] threshold;
		logic        slow_start;
	} cwu_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // [15:0] segments_acked, [47:16] bytes_in_flight
	logic [1:0]  s_axis_tuser = '0;   // [1:0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;        // [31:0] window_bytes, [63:32] threshold_bytes
	logic        m_axis_tuser;        // [0] in_slow_start
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Mirror of the block's registers and window state.
	logic [15:0] mss = SEG_SIZE_RST;
	logic [31:0] ss_numer = NUMERATOR_RST;
	logic [31:0] restart_window = INIT_WIN_RST;
	logic [31:0] restart_threshold = INIT_THR_RST;
	logic [31:0] cwnd = INIT_WIN_RST;
	logic [31:0] ssthresh = INIT_THR_RST;

	cwu_event_t  pending_events[$];
	cwu_result_t expected_results[$];
	cwu_event_t  drv_event;
	cwu_result_t got;
	cwu_result_t want;

	int unsigned events_queued = 0;
	int unsigned results_matched = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	int unsigned rx_run_left = 0;
	bit          rx_run_ready = 1'b1;
	bit          hold_req = 1'b0;
	bit          in_taken = 1'b0;

	congestion_window_update u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// Window growth clips at the all-ones byte count.
	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// Applies one event to the mirrored state and returns the beat it should produce.
	function automatic cwu_result_t apply_cwnd_event(input logic [1:0] op,
			input logic [15:0] acked, input logic [31:0] flight);
		cwu_result_t res;
		logic [15:0] left;
		logic [31:0] step;
		logic [31:0] floor2;
		logic [31:0] half;
		left = acked;
		case (op)
			OP_ACK: begin
				// One acked segment goes to the slow-start increment, rounded up.
				if (cwnd < ssthresh && left != 16'd0) begin
					if (cwnd == 32'd0) begin
						step = ss_numer;
					end else begin
						step = ss_numer / cwnd;
						if (ss_numer % cwnd != 32'd0)
							step = step + 32'd1;
					end
					cwnd = add_sat(cwnd, step);
					left = left - 16'd1;
				end
				if (cwnd >= ssthresh && left != 16'd0)
					cwnd = add_sat(cwnd, {17'd0, mss[15:1]});
			end
			OP_LOSS: begin
				floor2 = {15'd0, mss, 1'b0};
				half = flight >> 1;
				ssthresh = (floor2 > half) ? floor2 : half;
			end
			OP_RESTART: begin
				cwnd = restart_window;
				ssthresh = restart_threshold;
			end
			default: begin
			end
		endcase
		res.window = cwnd;
		res.threshold = ssthresh;
		res.slow_start = (cwnd < ssthresh);
		return res;
	endfunction

	task automatic push_event(input logic [1:0] op, input logic [15:0] acked,
			input logic [31:0] flight);
		cwu_event_t ev;
		ev.op = op;
		ev.acked = acked;
		ev.flight = flight;
		pending_events.push_back(ev);
		events_queued++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [15:0] seg, input logic [31:0] numer,
			input logic [31:0] win, input logic [31:0] thr);
		write_reg(REG_SEGMENT_SIZE, {16'd0, seg});
		write_reg(REG_SLOW_START_NUMER, numer);
		write_reg(REG_INITIAL_WINDOW, win);
		write_reg(REG_INITIAL_THRESHOLD, thr);
	endtask

	// Waits until every queued event has come back as a checked result beat.
	task automatic wait_drained();
		while (results_matched != events_queued)
			@(negedge clk);
	endtask

	function automatic logic [15:0] rand_acked();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return 16'($urandom_range(0, 3));
		else if (pick < 9)
			return 16'($urandom_range(0, 65535));
		else
			return 16'hFFFF;
	endfunction

	function automatic logic [31:0] rand_flight();
		return $urandom() >> $urandom_range(0, 31);
	endfunction

	// One random sequence: mostly restart, slow start, loss and recovery with random content.
	task automatic queue_sequence();
		int unsigned kind;
		int unsigned n;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			if ($urandom_range(0, 1) == 0)
				push_event(OP_RESTART, 16'($urandom()), $urandom());
			n = $urandom_range(1, 8);
			repeat (n)
				push_event(OP_ACK, rand_acked(), $urandom());
			push_event(OP_LOSS, 16'($urandom()), rand_flight());
			n = $urandom_range(1, 6);
			repeat (n)
				push_event(OP_ACK, rand_acked(), $urandom());
		end else if (kind < 9) begin
			n = $urandom_range(1, 4);
			repeat (n)
				push_event(2'($urandom_range(0, 3)), 16'($urandom()), $urandom());
		end else begin
			push_event(OP_LOSS, 16'd0, rand_flight());
			push_event(OP_ACK, 16'd0, 32'd0);
			push_event(OP_UNUSED, 16'($urandom()), $urandom());
			push_event(OP_ACK, rand_acked(), 32'd0);
		end
	endtask

	// Stimulus: directed events under reset defaults, then random phases per setting.
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_event(OP_ACK, 16'd0, 32'd0);
		push_event(OP_ACK, 16'd1, 32'hFFFF_FFFF);
		push_event(OP_ACK, 16'd2, 32'd0);
		push_event(OP_ACK, 16'hFFFF, 32'd0);
		push_event(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
		push_event(OP_LOSS, 16'd0, 32'd0);
		push_event(OP_ACK, 16'd0, 32'd0);
		push_event(OP_ACK, 16'd1, 32'd0);
		push_event(OP_ACK, 16'd3, 32'd0);
		push_event(OP_LOSS, 16'hFFFF, 32'hFFFF_FFFF);
		push_event(OP_ACK, 16'd1, 32'd0);
		push_event(OP_LOSS, 16'd0, 32'd2145);
		push_event(OP_LOSS, 16'd0, 32'd2144);
		push_event(OP_ACK, 16'd65535, 32'd0);
		push_event(OP_ACK, 16'd2, 32'd0);
		push_event(OP_RESTART, 16'hFFFF, 32'hFFFF_FFFF);
		push_event(OP_ACK, 16'd5, 32'd0);
		push_event(OP_LOSS, 16'd0, 32'h0000_0001);
		push_event(OP_UNUSED, 16'd0, 32'd0);
		push_event(OP_RESTART, 16'd0, 32'd0);
		wait_drained();

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_config(16'd1, 32'd1, 32'd1, 32'hFFFF_FFFF);
				1: set_config(16'hFFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
				2: set_config(16'd0, 32'd0, 32'd0, 32'd1);
				3: set_config(16'd1460, 32'd1027000, 32'd2920, 32'd65535);
				4: set_config(16'd2, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1);
				5: set_config(16'($urandom()), $urandom(), $urandom() >> $urandom_range(0, 31),
					$urandom());
				default: set_config(SEG_SIZE_RST, NUMERATOR_RST, INIT_WIN_RST, INIT_THR_RST);
			endcase
			// Each phase opens from a known state.
			push_event(OP_RESTART, 16'd0, 32'd0);
			while (events_queued - results_matched < PHASE_EVENTS)
				queue_sequence();
			if (phase == 1)
				hold_req = 1'b1;
			wait_drained();
		end

		repeat (60) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Sender: offers queued events in bursts with random gaps, holding each beat until taken.
	always @(negedge clk) begin
		if (arst_n && !(s_axis_tvalid && !in_taken)) begin
			in_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_events.size() > 0) begin
				drv_event = pending_events.pop_front();
				s_axis_tuser <= drv_event.op;
				s_axis_tdata <= {drv_event.flight, drv_event.acked};
				s_axis_tvalid <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
						: $urandom_range(0, 4);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random runs of ready and stall, plus one long hold-off on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (rx_run_left == 0) begin
					rx_run_ready = ($urandom_range(0, 9) < 7);
					rx_run_left = rx_run_ready ? $urandom_range(1, 40) : $urandom_range(1, 10);
				end
				rx_run_left--;
				m_axis_tready <= rx_run_ready;
			end
		end
	end

	// Monitor: tracks register writes, predicts accepted events and checks result beats.
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEGMENT_SIZE:      mss = cfg_data[15:0];
				REG_SLOW_START_NUMER:  ss_numer = cfg_data;
				REG_INITIAL_WINDOW:    restart_window = cfg_data;
				REG_INITIAL_THRESHOLD: restart_threshold = cfg_data;
				default: begin
				end
			endcase
		end
		if (s_axis_tvalid && s_axis_tready) begin
			expected_results.push_back(apply_cwnd_event(s_axis_tuser, s_axis_tdata[15:0],
				s_axis_tdata[47:16]));
			in_taken = 1'b1;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.window = m_axis_tdata[31:0];
			got.threshold = m_axis_tdata[63:32];
			got.slow_start = m_axis_tuser;
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result beat: window %0d threshold %0d slow %0b",
						got.window, got.threshold, got.slow_start);
			end else begin
				want = expected_results.pop_front();
				results_matched++;
				if (got != want) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						if (got.window != want.window)
							$display("result %0d window: expected %0d, got %0d",
								results_matched, want.window, got.window);
						if (got.threshold != want.threshold)
							$display("result %0d threshold: expected %0d, got %0d",
								results_matched, want.threshold, got.threshold);
						if (got.slow_start != want.slow_start)
							$display("result %0d in_slow_start: expected %0b, got %0b",
								results_matched, want.slow_start, got.slow_start);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
